[sv/csd_pkg.sv]
package csd_pkg;

  localparam int LOG_FRAC_BITS = 24;
  localparam int DIV_W = 37;
  localparam int STEP_W = 6;
  localparam logic [3:0] MAX_CASCADES = 4'd8;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef struct packed {
    logic [3:0]  cascade_count;
    logic [31:0] near_plane;
    logic [31:0] far_plane;
    logic [16:0] blend_weight;
  } csd_req_t;

  typedef struct packed {
    logic [31:0] split_distance;
    logic [3:0]  cascade_number;
    logic        last;
    logic        invalid;
  } csd_res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_NORM_N, ST_SQ_N, ST_STORE_N, ST_NORM_F, ST_SQ_F, ST_STORE_F,
    ST_SPLIT, ST_DIV, ST_EXP_INIT, ST_EXP, ST_EXP_FIN, ST_MIX_MUL, ST_MIX_SUM, ST_EMIT
  } csd_state_t;

  typedef struct packed {
    logic       load;
    logic       norm_init;
    logic       norm_far;
    logic       norm_step;
    logic       sq_step;
    logic       store_ln;
    logic       store_lf;
    logic       div_init;
    logic       div_step;
    logic       exp_init;
    logic       exp_step;
    logic       exp_fin;
    logic       mix_mul;
    logic       mix_sum;
    logic       emit;
    logic [4:0] step;
  } csd_cmd_t;

  typedef struct packed {
    logic empty;
    logic bad;
    logic norm_done;
    logic last;
  } csd_stat_t;

  typedef logic [31:0] csd_roots_t [LOG_FRAC_BITS];

  // Successive square roots of 2.0 in Q1.30, used by the exp2 steps.
  function automatic csd_roots_t make_roots();
    csd_roots_t tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    c = 64'd1 << 31;
    for (int j = 0; j < LOG_FRAC_BITS; j++) begin
      v = c << 30;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (int b = 0; b < 32; b++) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      c = res;
      tab[j] = c[31:0];
    end
    return tab;
  endfunction

  localparam csd_roots_t ROOTS = make_roots();

endpackage

[sv/cascade_split_distances_unit.sv]
// Computes the cascade split distances of the practical split scheme: an item is taken when
// start is high and busy is low, and then one result per cascade comes out, in order, each
// on the res port for a single cycle marked by strobe; the receiver cannot hold them off.
// For a valid item two log2 evaluations come first, each a bit-per-cycle normalization
// followed by multiply-based squaring steps, one per cycle. Each split before the last then
// runs the 37-step restoring divider and the 24 exp2 steps, which share one 32x32 multiplier
// with the squaring steps; the last split and all splits of an invalid item skip both.
module cascade_split_distances_unit
  import csd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  csd_req_t req,
  output logic     busy,
  output logic     strobe,
  output csd_res_t res
);

  csd_cmd_t  cmd;
  csd_stat_t stat;

  csd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  csd_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .res    (res)
  );

endmodule

[sv/csd_div.sv]
module csd_div
  import csd_pkg::*;
(
  input  logic             clk,
  input  logic             init,
  input  logic             step,
  input  logic [DIV_W-1:0] num_a,
  input  logic [DIV_W-1:0] num_b,
  input  logic [4:0]       den,
  output logic [DIV_W-1:0] quo_a,
  output logic [DIV_W-1:0] quo_b
);

  logic [4:0] rem_a;
  logic [4:0] rem_b;
  logic [5:0] try_a;
  logic [5:0] try_b;
  logic       ge_a;
  logic       ge_b;

  assign try_a = {rem_a, quo_a[DIV_W-1]};
  assign try_b = {rem_b, quo_b[DIV_W-1]};
  assign ge_a = try_a >= {1'b0, den};
  assign ge_b = try_b >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (init) begin
      quo_a <= num_a;
      quo_b <= num_b;
      rem_a <= 5'd0;
      rem_b <= 5'd0;
    end else if (step) begin
      quo_a <= {quo_a[DIV_W-2:0], ge_a};
      quo_b <= {quo_b[DIV_W-2:0], ge_b};
      rem_a <= ge_a ? 5'(try_a - {1'b0, den}) : try_a[4:0];
      rem_b <= ge_b ? 5'(try_b - {1'b0, den}) : try_b[4:0];
    end
  end

endmodule

[sv/csd_datapath.sv]
module csd_datapath
  import csd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  csd_req_t  req,
  input  csd_cmd_t  cmd,
  output csd_stat_t stat,
  output logic      strobe,
  output csd_res_t  res
);

  logic [3:0]       cnt;
  logic [31:0]      near_v;
  logic [31:0]      far_v;
  logic [16:0]      w;
  logic             bad;
  logic [3:0]       idx;
  logic [31:0]      m;
  logic [4:0]       k;
  logic [23:0]      frac;
  logic [28:0]      ln;
  logic [28:0]      lf;
  logic [28:0]      span;
  logic [28:0]      t;
  logic [23:0]      fsh;
  logic [30:0]      r;
  logic [31:0]      uni;
  logic [31:0]      logs;
  logic [48:0]      p1;
  logic [48:0]      p2;
  logic [31:0]      mix;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      prod;
  logic [32:0]      sq;
  logic [28:0]      lf_new;
  logic [DIV_W-1:0] num_a;
  logic [DIV_W-1:0] num_b;
  logic [DIV_W-1:0] quo_a;
  logic [DIV_W-1:0] quo_b;
  logic [29:0]      tsum;
  logic [62:0]      shifted;
  logic [32:0]      vexp;
  logic [49:0]      msum;
  logic [33:0]      mq;
  logic [31:0]      dist_sel;

  assign mul_a = cmd.exp_step ? {1'b0, r} : m;
  assign mul_b = cmd.exp_step ? ROOTS[cmd.step] : m;
  assign prod = mul_a * mul_b;
  assign sq = prod[63:31];
  assign lf_new = {k, frac};

  assign num_a = DIV_W'((34'(span) * 34'(idx) << 1) + 34'(cnt));
  assign num_b = DIV_W'((DIV_W'(far_v - near_v) * DIV_W'(idx) << 1) + DIV_W'(cnt));

  csd_div u_div (
    .clk   (clk),
    .init  (cmd.div_init),
    .step  (cmd.div_step),
    .num_a (num_a),
    .num_b (num_b),
    .den   ({cnt, 1'b0}),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  assign tsum = {1'b0, ln} + {1'b0, quo_a[28:0]};
  assign shifted = {32'd0, r} << t[28:24];
  assign vexp = 33'((shifted + (63'd1 << 29)) >> 30);
  assign msum = {1'b0, p1} + {1'b0, p2} + 50'd32768;
  assign mq = msum[49:16];

  always_comb begin
    if (bad) begin
      dist_sel = 32'd0;
    end else if (idx == cnt) begin
      dist_sel = far_v;
    end else begin
      dist_sel = mix;
    end
  end

  assign stat.empty = cnt == 4'd0;
  assign stat.bad = bad;
  assign stat.norm_done = m[31];
  assign stat.last = idx == cnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt <= (req.cascade_count > MAX_CASCADES) ? MAX_CASCADES : req.cascade_count;
      near_v <= req.near_plane;
      far_v <= req.far_plane;
      w <= (req.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : req.blend_weight;
      bad <= (req.near_plane == 32'd0) || (req.far_plane < req.near_plane);
      idx <= 4'd1;
    end else if (cmd.emit) begin
      idx <= idx + 4'd1;
    end
    if (cmd.norm_init) begin
      m <= cmd.norm_far ? far_v : near_v;
      k <= 5'd31;
      frac <= 24'd0;
    end else if (cmd.norm_step) begin
      m <= {m[30:0], 1'b0};
      k <= k - 5'd1;
    end else if (cmd.sq_step) begin
      m <= sq[32] ? sq[32:1] : sq[31:0];
      frac <= {frac[22:0], sq[32]};
    end
    if (cmd.store_ln) begin
      ln <= lf_new;
    end
    if (cmd.store_lf) begin
      lf <= lf_new;
      span <= (lf_new >= ln) ? 29'(lf_new - ln) : 29'd0;
    end
    if (cmd.exp_init) begin
      t <= (tsum > {1'b0, lf}) ? lf : tsum[28:0];
      fsh <= (tsum > {1'b0, lf}) ? lf[23:0] : tsum[23:0];
      r <= 31'd1 << 30;
      uni <= near_v + quo_b[31:0];
    end else if (cmd.exp_step) begin
      fsh <= {fsh[22:0], 1'b0};
      if (fsh[23]) begin
        r <= prod[60:30];
      end
    end
    if (cmd.exp_fin) begin
      logs <= vexp[32] ? 32'hFFFF_FFFF : vexp[31:0];
    end
    if (cmd.mix_mul) begin
      p1 <= logs * w;
      p2 <= uni * 17'(WEIGHT_ONE - w);
    end
    if (cmd.mix_sum) begin
      mix <= (mq > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : mq[31:0];
    end
    if (cmd.emit) begin
      res.split_distance <= dist_sel;
      res.cascade_number <= idx;
      res.last <= idx == cnt;
      res.invalid <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

[sv/csd_ctrl.sv]
module csd_ctrl
  import csd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  csd_stat_t stat,
  output logic      busy,
  output csd_cmd_t  cmd
);

  csd_state_t        state;
  csd_state_t        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next = step + STEP_W'(1);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (stat.empty) begin
          state_next = ST_IDLE;
        end else if (stat.bad) begin
          state_next = ST_SPLIT;
        end else begin
          state_next = ST_NORM_N;
        end
      end
      ST_NORM_N: begin
        step_next = '0;
        if (stat.norm_done) begin
          state_next = ST_SQ_N;
        end
      end
      ST_SQ_N: begin
        if (step == STEP_W'(LOG_FRAC_BITS - 1)) begin
          state_next = ST_STORE_N;
        end
      end
      ST_STORE_N: state_next = ST_NORM_F;
      ST_NORM_F: begin
        step_next = '0;
        if (stat.norm_done) begin
          state_next = ST_SQ_F;
        end
      end
      ST_SQ_F: begin
        if (step == STEP_W'(LOG_FRAC_BITS - 1)) begin
          state_next = ST_STORE_F;
        end
      end
      ST_STORE_F: state_next = ST_SPLIT;
      ST_SPLIT: begin
        step_next = '0;
        if (stat.bad || stat.last) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_W - 1)) begin
          state_next = ST_EXP_INIT;
        end
      end
      ST_EXP_INIT: begin
        step_next = '0;
        state_next = ST_EXP;
      end
      ST_EXP: begin
        if (step == STEP_W'(LOG_FRAC_BITS - 1)) begin
          state_next = ST_EXP_FIN;
        end
      end
      ST_EXP_FIN: state_next = ST_MIX_MUL;
      ST_MIX_MUL: state_next = ST_MIX_SUM;
      ST_MIX_SUM: state_next = ST_EMIT;
      ST_EMIT: state_next = stat.last ? ST_IDLE : ST_SPLIT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.step = step[4:0];
    unique case (state)
      ST_IDLE: cmd.load = start;
      ST_CHECK: cmd.norm_init = 1'b1;
      ST_NORM_N, ST_NORM_F: cmd.norm_step = !stat.norm_done;
      ST_SQ_N, ST_SQ_F: cmd.sq_step = 1'b1;
      ST_STORE_N: begin
        cmd.store_ln = 1'b1;
        cmd.norm_init = 1'b1;
        cmd.norm_far = 1'b1;
      end
      ST_STORE_F: cmd.store_lf = 1'b1;
      ST_SPLIT: cmd.div_init = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_EXP_INIT: cmd.exp_init = 1'b1;
      ST_EXP: cmd.exp_step = 1'b1;
      ST_EXP_FIN: cmd.exp_fin = 1'b1;
      ST_MIX_MUL: cmd.mix_mul = 1'b1;
      ST_MIX_SUM: cmd.mix_sum = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: cmd.load = 1'b0;
    endcase
  end

  assign busy = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule

[sv/csd_checker.sv]
module csd_checker
  import csd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     strobe,
  input csd_res_t res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an item was taken");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results came on adjacent cycles");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && res.invalid) |-> (res.split_distance == 32'd0))
    else $error("invalid result carries a nonzero distance");

  a_number_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (res.cascade_number != 4'd0 && res.cascade_number <= MAX_CASCADES))
    else $error("cascade number out of range");

endmodule

bind cascade_split_distances_unit csd_checker u_csd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .res    (res)
);

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     start;
  csd_req_t req;
  logic     busy;
  logic     strobe;
  csd_res_t res;

  csd_req_t pending_reqs[$];
  csd_res_t expected_splits[$];
  int       errors;
  int       send_idle_pct;
  int       idle_cycles;
  bit       accepted;

  cascade_split_distances_unit u_top (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .strobe(strobe), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] log2_q5_24(logic [31:0] x);
    int          k;
    logic [63:0] m;
    logic [31:0] frac;
    k = 31;
    frac = 32'd0;
    while (k > 0 && x[k] == 1'b0) k--;
    m = 64'(x) << (31 - k);
    for (int s = 0; s < LOG_FRAC_BITS; s++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (32'(k) << LOG_FRAC_BITS) | frac;
  endfunction

  function automatic logic [31:0] exp2_q5_24(logic [31:0] t);
    logic [4:0]  n;
    logic [23:0] f;
    logic [63:0] c;
    logic [63:0] r;
    logic [63:0] v;
    n = t[28:24];
    f = t[23:0];
    c = 64'd1 << 31;
    r = 64'd1 << 30;
    for (int j = 0; j < LOG_FRAC_BITS; j++) begin
      c = isqrt64(c << 30);
      if (f[23 - j]) r = (r * c) >> 30;
    end
    v = ((r << n) + (64'd1 << 29)) >> 30;
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic void predict_splits(csd_req_t rq);
    logic [3:0]   cnt;
    logic [16:0]  w;
    logic         bad;
    logic [31:0]  ln;
    logic [31:0]  lf;
    logic [31:0]  span;
    logic [63:0]  e;
    logic [63:0]  t;
    logic [63:0]  uni;
    logic [127:0] mix;
    csd_res_t     r;
    cnt = (rq.cascade_count > MAX_CASCADES) ? MAX_CASCADES : rq.cascade_count;
    w = (rq.blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : rq.blend_weight;
    bad = (rq.near_plane == 0) || (rq.far_plane < rq.near_plane);
    ln = 0;
    lf = 0;
    span = 0;
    if (!bad) begin
      ln = log2_q5_24(rq.near_plane);
      lf = log2_q5_24(rq.far_plane);
      span = (lf >= ln) ? lf - ln : 32'd0;
    end
    for (int i = 1; i <= cnt; i++) begin
      r.split_distance = 32'd0;
      if (!bad) begin
        if (i == cnt) begin
          r.split_distance = rq.far_plane;
        end else begin
          e = (64'(span) * i * 2 + cnt) / (64'(cnt) * 2);
          t = 64'(ln) + e;
          if (t > 64'(lf)) t = 64'(lf);
          uni = 64'(rq.near_plane)
              + (64'(rq.far_plane - rq.near_plane) * i * 2 + cnt) / (64'(cnt) * 2);
          mix = (128'(exp2_q5_24(t[31:0])) * w + 128'(uni) * (WEIGHT_ONE - w) + 128'd32768)
                >> 16;
          r.split_distance = (mix > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : mix[31:0];
        end
      end
      r.cascade_number = 4'(i);
      r.last = (i == cnt);
      r.invalid = bad;
      expected_splits.push_back(r);
    end
  endfunction

  function automatic csd_req_t make_req(int cnt, logic [31:0] nr, logic [31:0] fr, int w);
    csd_req_t rq;
    rq.cascade_count = 4'(cnt);
    rq.near_plane = nr;
    rq.far_plane = fr;
    rq.blend_weight = 17'(w);
    return rq;
  endfunction

  // Driver: a new item is offered at the falling edge; it is taken at the next rising
  // edge if busy is low there.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      accepted <= 1'b0;
    end else begin
      accepted <= start && !busy;
      if (start && !busy) predict_splits(req);
      if (strobe) begin
        if (expected_splits.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          errors++;
        end else begin
          csd_res_t x;
          x = expected_splits.pop_front();
          if (res.split_distance !== x.split_distance || res.cascade_number !==
              x.cascade_number || res.last !== x.last || res.invalid !== x.invalid) begin
            $display("%0t: mismatch expected dist=%h num=%0d last=%b inv=%b",
                     $time, x.split_distance, x.cascade_number, x.last, x.invalid);
            $display("%0t:          actual   dist=%h num=%0d last=%b inv=%b",
                     $time, res.split_distance, res.cascade_number, res.last, res.invalid);
            errors++;
          end
        end
      end
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_splits.size() > 0 || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    logic [31:0] nr;
    logic [31:0] fr;
    int          c;
    int          w;
    int          kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      c = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(4, 1);
      nr = ($urandom_range(1) == 1) ? $urandom_range(32'h0008_0000, 1) : $urandom;
      fr = nr + $urandom_range(32'hFFFF_FFFF - nr);
      if (kind == 0) nr = 32'd0;
      if (kind == 1) begin
        fr = $urandom;
        nr = $urandom;
      end
      w = ($urandom_range(7) == 0) ? $urandom_range(17'h1FFFF) : $urandom_range(65536);
      pending_reqs.push_back(make_req(c, nr, fr, w));
    end
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    pending_reqs.push_back(make_req(0, 32'h0001_0000, 32'h0064_0000, 32768));
    pending_reqs.push_back(make_req(1, 32'h0001_0000, 32'h0064_0000, 32768));
    pending_reqs.push_back(make_req(8, 32'h0000_8000, 32'h03E8_0000, 49152));
    pending_reqs.push_back(make_req(15, 32'h0001_0000, 32'h0064_0000, 32768));
    pending_reqs.push_back(make_req(9, 32'd1, 32'hFFFF_FFFF, 65536));
    pending_reqs.push_back(make_req(4, 32'd1, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(make_req(4, 32'h0001_0000, 32'h0100_0000, 17'h1FFFF));
    pending_reqs.push_back(make_req(4, 32'h0001_0000, 32'h0100_0000, 65537));
    pending_reqs.push_back(make_req(3, 32'd0, 32'h0100_0000, 32768));
    pending_reqs.push_back(make_req(3, 32'h0200_0000, 32'h0100_0000, 32768));
    pending_reqs.push_back(make_req(5, 32'h0100_0000, 32'h0100_0000, 32768));
    pending_reqs.push_back(make_req(8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65536));
    pending_reqs.push_back(make_req(8, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 12345));
    pending_reqs.push_back(make_req(2, 32'h8000_0000, 32'hFFFF_FFFF, 1));
    pending_reqs.push_back(make_req(7, 32'h5555_5555, 32'hAAAA_AAAA, 65535));
    pending_reqs.push_back(make_req(6, 32'h0000_0001, 32'h0000_0002, 40000));
    pending_reqs.push_back(make_req(8, 32'd0, 32'd0, 0));
    pending_reqs.push_back(make_req(10, 32'h0000_0003, 32'h7FFF_FFFF, 65536));
    wait_drained();

    queue_random(60);
    wait_drained();
    send_idle_pct = 51;
    queue_random(60);
    wait_drained();
    send_idle_pct = 25;
    queue_random(50);
    wait_drained();
    send_idle_pct = 0;
    queue_random(60);
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[cascade_split_distances_unit.f]
sv/csd_pkg.sv
sv/csd_div.sv
sv/csd_datapath.sv
sv/csd_ctrl.sv
sv/cascade_split_distances_unit.sv
sv/csd_checker.sv
bench/tb_top.sv
